// ===== sv/icfdm_pkg.sv =====
// Package: shared widths, constants and controller/datapath command types for the meter.
`timescale 1ns / 1ps
`default_nettype none
package icfdm_pkg;

   localparam int TIMER_WIDTH = 32;
   localparam int IN_W        = 32;
   localparam int CLK_W       = 30;
   localparam int DUTY_W      = 7;
   localparam int PROD_W      = TIMER_WIDTH + DUTY_W;

   localparam int FREQ_STEPS  = CLK_W;
   localparam int DUTY_STEPS  = DUTY_W;
   localparam int CNT_W       = $clog2(FREQ_STEPS);

   localparam logic [CLK_W-1:0]  CLK_HZ_RESET = CLK_W'(1000000);
   localparam logic [DUTY_W-1:0] DUTY_FULL    = DUTY_W'(100);

   typedef logic [TIMER_WIDTH-1:0] stamp_type;
   typedef logic [PROD_W-1:0]      prod_type;

   typedef struct packed {
      logic store_first;
      logic store_fall;
      logic store_period;
      logic freq_start;
      logic duty_start;
      logic div_step;
      logic freq_write;
      logic duty_write;
      logic duty_sat;
      logic load_out;
      logic out_done;
      logic out_expect_falling;
      logic out_valid;
   } cmd_type;

   typedef struct packed {
      logic period_zero;
      logic high_sat;
   } status_type;

endpackage
`default_nettype wire

// ===== sv/icfdm_req_if.sv =====
// Interface: capture timestamp channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface icfdm_req_if;
   logic                       valid;
   logic                       ready;
   logic [icfdm_pkg::IN_W-1:0] capture_time;

   modport source (output valid, output capture_time, input ready);
   modport sink   (input valid, input capture_time, output ready);
endinterface
`default_nettype wire

// ===== sv/icfdm_rsp_if.sv =====
// Interface: measurement result channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface icfdm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [icfdm_pkg::CLK_W-1:0]  frequency_hz;
   logic [icfdm_pkg::DUTY_W-1:0] duty_percent;
   logic                         measure_valid;
   logic                         period_done;
   logic                         expect_falling;

   modport source (output valid, output frequency_hz, output duty_percent,
                   output measure_valid, output period_done, output expect_falling,
                   input ready);
   modport sink   (input valid, input frequency_hz, input duty_percent,
                   input measure_valid, input period_done, input expect_falling,
                   output ready);
endinterface
`default_nettype wire

// ===== sv/input_capture_frequency_duty_meter.sv =====
// Top level: input capture frequency and duty meter, controller plus datapath.
//
//   port   dir  handshake     payload
//   req    in   valid/ready   capture_time[31:0]
//   rsp    out  valid/ready   frequency_hz[29:0], duty_percent[6:0], measure_valid,
//                             period_done, expect_falling
//   csr    in   csr_wr_en     csr_wr_data[29:0] = count_clock_hz
//
// A first rising or falling edge item passes straight to the load state after its accept.
// A second rising edge item passes a check state, 30 steps of the shared restoring
// divider for the frequency, a duty set-up state, 7 steps for the duty, then the load;
// a saturated duty skips the 7 steps, and a zero period skips both divisions.
// A new item is accepted once the previous result is in the output register.
// Synchronous active-high reset; count_clock_hz resets to 1000000.
// A stalled result holds in the output register; the block then waits before loading.
`timescale 1ns / 1ps
`default_nettype none
module input_capture_frequency_duty_meter (
   input  wire logic                         clock,
   input  wire logic                         reset,
   icfdm_req_if.sink                         req,
   icfdm_rsp_if.source                       rsp,
   input  wire logic                         csr_wr_en,
   input  wire logic [icfdm_pkg::CLK_W-1:0]  csr_wr_data
);

   icfdm_pkg::cmd_type     cmd;
   icfdm_pkg::status_type  status;

   icfdm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .status    (status),
      .cmd       (cmd)
   );

   icfdm_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .capture_time   (req.capture_time),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .cmd            (cmd),
      .status         (status),
      .frequency_hz   (rsp.frequency_hz),
      .duty_percent   (rsp.duty_percent),
      .measure_valid  (rsp.measure_valid),
      .period_done    (rsp.period_done),
      .expect_falling (rsp.expect_falling)
   );

   // one item at a time: no accept right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("item accepted while previous item still in work");

   a_done_implies_valid: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.period_done |-> rsp.measure_valid)
      else $error("completed period without measure_valid");

   a_done_not_falling: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.period_done |-> !rsp.expect_falling)
      else $error("completed period but next edge marked falling");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.duty_percent <= icfdm_pkg::DUTY_FULL)
      else $error("duty above full scale");

endmodule
`default_nettype wire

// ===== sv/icfdm_ctrl.sv =====
// Controller: capture phase tracking, divider sequencing and result handshake.
`timescale 1ns / 1ps
`default_nettype none
module icfdm_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   rsp_ready,
   output logic                        rsp_valid,
   input  wire icfdm_pkg::status_type  status,
   output icfdm_pkg::cmd_type          cmd
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_CHECK     = 3'd1;
   localparam logic [2:0] S_FREQ      = 3'd2;
   localparam logic [2:0] S_DUTY_INIT = 3'd3;
   localparam logic [2:0] S_DUTY      = 3'd4;
   localparam logic [2:0] S_LOAD      = 3'd5;

   localparam logic [1:0] PH_RISE1 = 2'd0;
   localparam logic [1:0] PH_FALL  = 2'd1;
   localparam logic [1:0] PH_RISE2 = 2'd2;

   localparam logic [icfdm_pkg::CNT_W-1:0] FREQ_LAST =
      icfdm_pkg::CNT_W'(icfdm_pkg::FREQ_STEPS - 1);
   localparam logic [icfdm_pkg::CNT_W-1:0] DUTY_LAST =
      icfdm_pkg::CNT_W'(icfdm_pkg::DUTY_STEPS - 1);

   logic [2:0]                   state_ff, state_in;
   logic [1:0]                   phase_ff, phase_in;
   logic                         done_ff, done_in;
   logic                         meas_ff, meas_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [icfdm_pkg::CNT_W-1:0]  cnt_ff, cnt_in;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      done_in      = done_ff;
      meas_in      = meas_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      req_ready    = 1'b0;
      cmd          = '0;

      // drop the result once the sink takes it
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (phase_ff)
                  PH_FALL: begin
                     cmd.store_fall = 1'b1;
                     phase_in       = PH_RISE2;
                     done_in        = 1'b0;
                     state_in       = S_LOAD;
                  end
                  PH_RISE2: begin
                     cmd.store_period = 1'b1;
                     phase_in         = PH_RISE1;
                     done_in          = 1'b1;
                     meas_in          = 1'b1;
                     state_in         = S_CHECK;
                  end
                  default: begin
                     // unreachable code 3 behaves as a first rising edge
                     cmd.store_first = 1'b1;
                     phase_in        = PH_FALL;
                     done_in         = 1'b0;
                     state_in        = S_LOAD;
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (status.period_zero) begin
               state_in = S_LOAD;
            end else begin
               cmd.freq_start = 1'b1;
               cnt_in         = '0;
               state_in       = S_FREQ;
            end
         end
         S_FREQ: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == FREQ_LAST) begin
               cmd.freq_write = 1'b1;
               state_in       = S_DUTY_INIT;
            end else begin
               cnt_in = cnt_ff + icfdm_pkg::CNT_W'(1);
            end
         end
         S_DUTY_INIT: begin
            if (status.high_sat) begin
               cmd.duty_write = 1'b1;
               cmd.duty_sat   = 1'b1;
               state_in       = S_LOAD;
            end else begin
               cmd.duty_start = 1'b1;
               cnt_in         = '0;
               state_in       = S_DUTY;
            end
         end
         S_DUTY: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == DUTY_LAST) begin
               cmd.duty_write = 1'b1;
               state_in       = S_LOAD;
            end else begin
               cnt_in = cnt_ff + icfdm_pkg::CNT_W'(1);
            end
         end
         S_LOAD: begin
            // hold until the output slot is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      cmd.out_done           = done_ff;
      cmd.out_expect_falling = (phase_ff == PH_FALL);
      cmd.out_valid          = meas_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_RISE1;
         done_ff      <= 1'b0;
         meas_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         done_ff      <= done_in;
         meas_ff      <= meas_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== sv/icfdm_dp.sv =====
// Datapath: timestamp registers, shared restoring divider and result registers.
`timescale 1ns / 1ps
`default_nettype none
module icfdm_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [icfdm_pkg::IN_W-1:0]    capture_time,
   input  wire logic                          csr_wr_en,
   input  wire logic [icfdm_pkg::CLK_W-1:0]   csr_wr_data,
   input  wire icfdm_pkg::cmd_type            cmd,
   output icfdm_pkg::status_type              status,
   output logic [icfdm_pkg::CLK_W-1:0]        frequency_hz,
   output logic [icfdm_pkg::DUTY_W-1:0]       duty_percent,
   output logic                               measure_valid,
   output logic                               period_done,
   output logic                               expect_falling
);

   localparam int TW = icfdm_pkg::TIMER_WIDTH;
   localparam int CW = icfdm_pkg::CLK_W;
   localparam int DW = icfdm_pkg::DUTY_W;

   logic [CW-1:0]         clk_hz_ff;
   icfdm_pkg::stamp_type  first_ff, first_in;
   icfdm_pkg::stamp_type  fall_ff, fall_in;
   icfdm_pkg::stamp_type  high_ff, high_in;
   icfdm_pkg::stamp_type  period_ff, period_in;
   icfdm_pkg::prod_type   h100_ff, h100_in;
   logic [CW-1:0]         freq_ff, freq_in;
   logic [DW-1:0]         duty_ff, duty_in;

   icfdm_pkg::stamp_type  rem_ff, rem_in;
   logic [CW-1:0]         dsr_ff, dsr_in;
   logic [CW-1:0]         quo_ff, quo_in;

   logic [CW-1:0]         out_freq_ff;
   logic [DW-1:0]         out_duty_ff;
   logic                  out_valid_ff, out_done_ff, out_fall_ff;

   icfdm_pkg::stamp_type  stamp;
   logic [TW:0]           shifted;
   logic [TW:0]           diff;
   logic                  qbit;

   assign stamp   = icfdm_pkg::stamp_type'(capture_time);
   assign shifted = {rem_ff, dsr_ff[CW-1]};
   assign diff    = shifted - {1'b0, period_ff};
   assign qbit    = ~diff[TW];

   always_comb begin
      first_in  = first_ff;
      fall_in   = fall_ff;
      high_in   = high_ff;
      period_in = period_ff;
      h100_in   = h100_ff;
      freq_in   = freq_ff;
      duty_in   = duty_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      quo_in    = quo_ff;

      if (cmd.store_first) begin
         first_in = stamp;
      end
      if (cmd.store_fall) begin
         fall_in = stamp;
         high_in = stamp - first_ff;
      end
      if (cmd.store_period) begin
         // high plus low, wrapping at the timer width
         period_in = high_ff + (stamp - fall_ff);
         h100_in   = icfdm_pkg::prod_type'(high_ff)
                   * icfdm_pkg::prod_type'(icfdm_pkg::DUTY_FULL);
      end

      priority if (cmd.freq_start) begin
         rem_in = '0;
         dsr_in = clk_hz_ff;
         quo_in = '0;
      end else if (cmd.duty_start) begin
         // 100*high < 128*period, so seven quotient bits cover it
         rem_in = h100_ff[icfdm_pkg::PROD_W-1:DW];
         dsr_in = {h100_ff[DW-1:0], {(CW-DW){1'b0}}};
         quo_in = '0;
      end else if (cmd.div_step) begin
         rem_in = qbit ? diff[TW-1:0] : shifted[TW-1:0];
         dsr_in = {dsr_ff[CW-2:0], 1'b0};
         quo_in = {quo_ff[CW-2:0], qbit};
      end

      if (cmd.freq_write) begin
         freq_in = quo_in;
      end
      if (cmd.duty_write) begin
         duty_in = cmd.duty_sat ? icfdm_pkg::DUTY_FULL : quo_in[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_hz_ff <= icfdm_pkg::CLK_HZ_RESET;
         first_ff  <= '0;
         fall_ff   <= '0;
         high_ff   <= '0;
         freq_ff   <= '0;
         duty_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            clk_hz_ff <= csr_wr_data;
         end
         first_ff <= first_in;
         fall_ff  <= fall_in;
         high_ff  <= high_in;
         freq_ff  <= freq_in;
         duty_ff  <= duty_in;
      end
   end

   always_ff @(posedge clock) begin
      period_ff <= period_in;
      h100_ff   <= h100_in;
      rem_ff    <= rem_in;
      dsr_ff    <= dsr_in;
      quo_ff    <= quo_in;
      if (cmd.load_out) begin
         out_freq_ff  <= freq_ff;
         out_duty_ff  <= duty_ff;
         out_valid_ff <= cmd.out_valid;
         out_done_ff  <= cmd.out_done;
         out_fall_ff  <= cmd.out_expect_falling;
      end
   end

   assign status.period_zero = (period_ff == '0);
   assign status.high_sat    = (high_ff >= period_ff);

   assign frequency_hz   = out_freq_ff;
   assign duty_percent   = out_duty_ff;
   assign measure_valid  = out_valid_ff;
   assign period_done    = out_done_ff;
   assign expect_falling = out_fall_ff;

endmodule
`default_nettype wire
